>>> hdl/sclc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclc_pkg
// Shared types and constants for the snooping cache LRU controller.
// ----------------------------------------------------------------------------
package sclc_pkg;

   localparam int NumSets   = 64;
   localparam int MaxWays   = 4;
   localparam int TagBits   = 20;
   localparam int SetBits   = $clog2(NumSets);
   localparam int WayBits   = $clog2(MaxWays);
   localparam int RankBits  = 2;
   localparam int LatBits   = 14;
   localparam logic [LatBits-1:0] LatMax = '1;
   localparam logic [7:0] MemCycles = 8'd100;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_SET   = 2'd3;

   localparam logic [2:0] ST_I  = 3'd0;
   localparam logic [2:0] ST_S  = 3'd1;
   localparam logic [2:0] ST_E  = 3'd2;
   localparam logic [2:0] ST_M  = 3'd3;
   localparam logic [2:0] ST_MD = 3'd4;

   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_WAYS  = 2'd1;
   localparam logic [1:0] CSR_WORDS = 2'd2;

   typedef struct packed {
      logic                valid;
      logic [TagBits-1:0]  tag;
      logic [2:0]          state;
      logic [RankBits-1:0] rank;
   } line_type;

   typedef line_type [MaxWays-1:0] set_row_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [TagBits-1:0] tag;
      logic               other;
      logic [3:0]         sharers;
      logic [2:0]         want;
   } req_type;

   typedef struct packed {
      logic [LatBits-1:0] latency;
      logic               hit;
      logic [2:0]         line_state;
      logic               wrote_back;
      logic               shared_access;
      logic [4:0]         data_traffic;
      logic [3:0]         updates_sent;
   } rsp_type;

endpackage

>>> hdl/snooping_cache_lru_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snooping_cache_lru_controller_top
// Set-associative tag store with true-LRU replacement, MESI or Dragon.
// ----------------------------------------------------------------------------
// In each transaction the set row is read from a synchronous memory, then
// updated and written back at the end of the
// update cycle, and the result strobes out in the cycle after that.
// busy is high during the update cycle, so start is not taken then and a new
// transaction waits until the last update is done. The receiver cannot stall;
// rsp_valid is a single-cycle strobe. After reset a clearing pass over all 64
// set rows (one set row per cycle) runs with busy high; configuration writes are taken at any time.
module snooping_cache_lru_controller_top
   import sclc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [5:0]         req_set_index,
   input  logic [19:0]        req_line_tag,
   input  logic               req_other_copy,
   input  logic [3:0]         req_sharer_count,
   input  logic [2:0]         req_state_to_set,
   output logic               rsp_valid,
   output logic [13:0]        rsp_latency,
   output logic               rsp_hit,
   output logic [2:0]         rsp_line_state,
   output logic               rsp_wrote_back,
   output logic               rsp_shared_access,
   output logic [4:0]         rsp_data_traffic,
   output logic [3:0]         rsp_updates_sent,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [8:0]         csr_data
);

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_WORK  = 3'b100
   } fsm_type;

   fsm_type              state_ff, state_in;
   logic [SetBits:0]     clr_ff, clr_in;
   logic                 mode_ff;
   logic [2:0]           ways_ff;
   logic [8:0]           words_ff;
   req_type              req_ff;
   logic [SetBits-1:0]   set_ff;
   set_row_type          mem [NumSets];
   set_row_type          rd_ff, row_new;
   rsp_type              rsp_c, rsp_ff;
   logic                 rsp_valid_ff;
   logic                 accept;

   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (SetBits+1)'(NumSets - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_WORK;
         end
         S_WORK: state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   sclc_update u_update (
      .req      (req_ff),
      .row_in   (rd_ff),
      .dragon   (mode_ff),
      .ways_cfg (ways_ff),
      .words    (words_ff),
      .row_out  (row_new),
      .rsp      (rsp_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         mode_ff <= 1'b0;
         ways_ff <= 3'd4;
         words_ff <= 9'd8;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= (state_ff == S_WORK);
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MODE:  mode_ff <= csr_data[0];
               CSR_WAYS:  ways_ff <= csr_data[2:0];
               CSR_WORDS: words_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= '{op: req_operation, tag: req_line_tag, other: req_other_copy,
                     sharers: req_sharer_count, want: req_state_to_set};
         set_ff <= req_set_index;
         rd_ff <= mem[req_set_index];
      end
      if (state_ff == S_CLEAR) mem[clr_ff[SetBits-1:0]] <= '0;
      else if (state_ff == S_WORK) mem[set_ff] <= row_new;
      if (state_ff == S_WORK) rsp_ff <= rsp_c;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_latency = rsp_ff.latency;
   assign rsp_hit = rsp_ff.hit;
   assign rsp_line_state = rsp_ff.line_state;
   assign rsp_wrote_back = rsp_ff.wrote_back;
   assign rsp_shared_access = rsp_ff.shared_access;
   assign rsp_data_traffic = rsp_ff.data_traffic;
   assign rsp_updates_sent = rsp_ff.updates_sent;

`ifndef SYNTHESIS
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WORK) |=> rsp_valid)
      else $error("result strobe missing after update");
   a_no_accept_in_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WORK) |-> busy)
      else $error("busy low during update");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
`endif

endmodule

>>> hdl/sclc_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclc_update
// Per-set access logic: tag match, coherence transition, LRU update,
// victim choice and cost figures.
// ----------------------------------------------------------------------------
module sclc_update
   import sclc_pkg::*;
(
   input  req_type     req,
   input  set_row_type row_in,
   input  logic        dragon,
   input  logic [2:0]  ways_cfg,
   input  logic [8:0]  words,
   output set_row_type row_out,
   output rsp_type     rsp
);

   always_comb begin
      set_row_type       r;
      logic              found;
      logic [WayBits-1:0] fw;
      logic [2:0]        cur, st, ways;
      logic              is_write, hit, wb, shared;
      logic [RankBits-1:0] rk;
      logic [2:0]        count;
      logic              vfound;
      logic [WayBits-1:0] vw;
      logic [RankBits-1:0] best;
      logic              ins;
      logic [9:0]        xfer;
      logic [15:0]       lat;
      logic [4:0]        traffic;
      logic [3:0]        upd;
      logic [13:0]       uxfer;

      r = row_in;
      found = 1'b0;
      fw = '0;
      rk = '0;
      hit = 1'b0; wb = 1'b0; shared = 1'b0; st = ST_I;
      lat = '0; traffic = '0; upd = '0;
      is_write = (req.op == OP_WRITE);
      xfer = {words, 1'b0};
      uxfer = 14'(req.sharers) * 14'(xfer);
      ways = ways_cfg;
      if (ways == 3'd0) ways = 3'd1;
      if (ways > 3'(MaxWays)) ways = 3'(MaxWays);
      count = '0; vfound = 1'b0; vw = '0; best = '0; ins = 1'b0;

      for (int w = MaxWays - 1; w >= 0; w--) begin
         if (r[w].valid && r[w].tag == req.tag) begin
            found = 1'b1;
            fw = WayBits'(w);
         end
      end
      cur = r[fw].state;

      if (req.op == OP_QUERY || req.op == OP_SET) begin
         if (found) begin
            if (req.op == OP_SET && req.want <= ST_MD) r[fw].state = req.want;
            hit = 1'b1;
            st = r[fw].state;
         end
      end else if (found && cur != ST_I) begin
         hit = 1'b1;
         lat = 16'd1;
         st = cur;
         if (!is_write) begin
            shared = dragon ? (cur == ST_S || cur == ST_M) : (cur == ST_S);
         end else if (!dragon) begin
            if (cur == ST_E) st = ST_M;
            else if (cur == ST_S) begin
               shared = 1'b1; st = ST_M; upd = req.sharers;
               lat = lat + 16'({req.sharers, 1'b0});
            end
         end else begin
            if (cur == ST_E) st = ST_MD;
            else if (cur == ST_S || cur == ST_M) begin
               if (!req.other) st = ST_MD;
               else begin
                  shared = 1'b1; st = ST_M; upd = req.sharers;
                  traffic = 5'(req.sharers);
                  lat = lat + 16'(uxfer);
               end
            end
         end
         r[fw].state = st;
         rk = r[fw].rank;
         for (int w = 0; w < MaxWays; w++) begin
            if (r[w].valid && r[w].rank < rk) r[w].rank = r[w].rank + 1'b1;
         end
         r[fw].rank = '0;
      end else begin
         lat = is_write ? 16'd1 : 16'd0;
         if (found) begin
            rk = r[fw].rank;
            r[fw].valid = 1'b0;
            for (int w = 0; w < MaxWays; w++) begin
               if (r[w].valid && r[w].rank > rk) r[w].rank = r[w].rank - 1'b1;
            end
         end
         for (int w = 0; w < MaxWays; w++) count = count + 3'(r[w].valid);
         if (count >= ways) begin
            for (int w = 0; w < MaxWays; w++) begin
               if (r[w].valid && (!vfound || r[w].rank > best)) begin
                  vfound = 1'b1; vw = WayBits'(w); best = r[w].rank;
               end
            end
            if (vfound) begin
               if (r[vw].state == ST_M || r[vw].state == ST_MD) begin
                  wb = 1'b1; lat = lat + 16'(MemCycles); traffic = traffic + 5'd1;
               end
               r[vw].valid = 1'b0;
               for (int w = 0; w < MaxWays; w++) begin
                  if (r[w].valid && r[w].rank > best) r[w].rank = r[w].rank - 1'b1;
               end
            end
         end
         traffic = traffic + 5'd1;
         if (!req.other) begin
            lat = lat + 16'(MemCycles);
            st = is_write ? (dragon ? ST_MD : ST_M) : ST_E;
         end else begin
            shared = 1'b1;
            lat = lat + 16'(xfer);
            if (!is_write) st = ST_S;
            else begin
               st = ST_M;
               upd = req.sharers;
               if (dragon) begin
                  traffic = traffic + 5'(req.sharers);
                  lat = lat + 16'(uxfer);
               end else begin
                  lat = lat + 16'({req.sharers, 1'b0});
               end
            end
         end
         for (int w = 0; w < MaxWays; w++) begin
            if (!ins && !r[w].valid) begin
               ins = 1'b1;
               for (int v = 0; v < MaxWays; v++) begin
                  if (r[v].valid && r[v].rank != '1) r[v].rank = r[v].rank + 1'b1;
               end
               r[w].valid = 1'b1;
               r[w].tag = req.tag;
               r[w].state = st;
               r[w].rank = '0;
            end
         end
      end

      row_out = r;
      rsp.latency = (lat > 16'(LatMax)) ? LatMax : lat[LatBits-1:0];
      rsp.hit = hit;
      rsp.line_state = st;
      rsp.wrote_back = wb;
      rsp.shared_access = shared;
      rsp.data_traffic = traffic;
      rsp.updates_sent = upd;
   end

endmodule

>>> tb/snooping_cache_lru_controller_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snooping_cache_lru_controller_top_tb
// Self-checking bench for the snooping cache LRU controller.
// ----------------------------------------------------------------------------
// A directed table walks reads, writes, snoops, stale lines, evictions and
// ignored state values. Random phases follow under several register
// settings, including the extremes. A behavioural model of the tag store, or for
// typed table rows a fixed entry, predicts each response; responses match in order.
// ----------------------------------------------------------------------------
module snooping_cache_lru_controller_top_tb;
   import sclc_pkg::*;

   typedef struct packed {
      logic [1:0]  op;
      logic [5:0]  set;
      logic [19:0] tag;
      logic        other;
      logic [3:0]  sharers;
      logic [2:0]  want;
   } access_type;

   typedef struct packed {
      access_type acc;
      logic       typed;
      rsp_type    rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]  req_operation = OP_READ;
   logic [5:0]  req_set_index = '0;
   logic [19:0] req_line_tag = '0;
   logic        req_other_copy = 1'b0;
   logic [3:0]  req_sharer_count = '0;
   logic [2:0]  req_state_to_set = ST_I;
   logic        rsp_valid;
   logic [13:0] rsp_latency;
   logic        rsp_hit;
   logic [2:0]  rsp_line_state;
   logic        rsp_wrote_back;
   logic        rsp_shared_access;
   logic [4:0]  rsp_data_traffic;
   logic [3:0]  rsp_updates_sent;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_MODE;
   logic [8:0]  csr_data = '0;

   snooping_cache_lru_controller_top dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // tag store mirror
   logic        m_valid [NumSets][MaxWays];
   logic [19:0] m_tag   [NumSets][MaxWays];
   logic [2:0]  m_state [NumSets][MaxWays];
   int          m_rank  [NumSets][MaxWays];
   logic        m_dragon;
   int          m_ways;
   int          m_words;

   rsp_type expected_rsp_q[$];
   int      errors = 0;
   bit      allow_idle = 1'b1;

   function automatic void age_lines(int s, int limit);
      for (int w = 0; w < MaxWays; w++)
         if (m_valid[s][w] && m_rank[s][w] < limit) m_rank[s][w]++;
   endfunction

   function automatic void drop_line(int s, int w);
      int r;
      r = m_rank[s][w];
      m_valid[s][w] = 1'b0;
      for (int v = 0; v < MaxWays; v++)
         if (m_valid[s][v] && m_rank[s][v] > r) m_rank[s][v]--;
   endfunction

   function automatic rsp_type cache_access(access_type a);
      rsp_type r;
      int s, found, ways, xfer, lat, traffic, upd, cnt, victim, best;
      logic [2:0] cur, st;
      logic hit, wb, shared, wr;
      s = a.set; found = -1; ways = m_ways; xfer = 2 * m_words;
      lat = 0; traffic = 0; upd = 0; cnt = 0;
      hit = 0; wb = 0; shared = 0; st = ST_I;
      if (ways < 1) ways = 1;
      if (ways > MaxWays) ways = MaxWays;
      for (int w = 0; w < MaxWays; w++)
         if (m_valid[s][w] && m_tag[s][w] == a.tag && found < 0) found = w;
      if (a.op == OP_QUERY || a.op == OP_SET) begin
         if (found >= 0) begin
            if (a.op == OP_SET && a.want <= ST_MD) m_state[s][found] = a.want;
            hit = 1;
            st = m_state[s][found];
         end
      end else begin
         wr = (a.op == OP_WRITE);
         lat = wr ? 1 : 0;
         if (found >= 0 && m_state[s][found] != ST_I) begin
            cur = m_state[s][found];
            hit = 1; lat = 1; st = cur;
            if (!wr) begin
               shared = m_dragon ? (cur == ST_S || cur == ST_M) : (cur == ST_S);
            end else if (!m_dragon) begin
               if (cur == ST_E) st = ST_M;
               else if (cur == ST_S) begin
                  shared = 1; st = ST_M; upd = a.sharers; lat += 2 * upd;
               end
            end else begin
               if (cur == ST_E) st = ST_MD;
               else if (cur == ST_S || cur == ST_M) begin
                  if (!a.other) st = ST_MD;
                  else begin
                     shared = 1; st = ST_M; upd = a.sharers;
                     traffic += upd; lat += upd * xfer;
                  end
               end
            end
            m_state[s][found] = st;
            age_lines(s, m_rank[s][found]);
            m_rank[s][found] = 0;
         end else begin
            if (found >= 0) drop_line(s, found);
            for (int w = 0; w < MaxWays; w++) cnt += m_valid[s][w];
            if (cnt >= ways) begin
               victim = -1; best = 0;
               for (int w = 0; w < MaxWays; w++)
                  if (m_valid[s][w] && (victim < 0 || m_rank[s][w] > best)) begin
                     victim = w; best = m_rank[s][w];
                  end
               if (victim >= 0) begin
                  if (m_state[s][victim] == ST_M || m_state[s][victim] == ST_MD) begin
                     wb = 1; lat += MemCycles; traffic++;
                  end
                  drop_line(s, victim);
               end
            end
            traffic++;
            if (!a.other) begin
               lat += MemCycles;
               st = wr ? (m_dragon ? ST_MD : ST_M) : ST_E;
            end else begin
               shared = 1;
               lat += xfer;
               if (!wr) st = ST_S;
               else begin
                  st = ST_M; upd = a.sharers;
                  if (m_dragon) begin
                     traffic += upd; lat += upd * xfer;
                  end else lat += 2 * upd;
               end
            end
            for (int w = 0; w < MaxWays; w++)
               if (!m_valid[s][w]) begin
                  age_lines(s, 255);
                  m_valid[s][w] = 1; m_tag[s][w] = a.tag;
                  m_state[s][w] = st; m_rank[s][w] = 0;
                  break;
               end
         end
      end
      if (lat > LatMax) lat = LatMax;
      r.latency = 14'(lat);
      r.hit = hit;
      r.line_state = st;
      r.wrote_back = wb;
      r.shared_access = shared;
      r.data_traffic = 5'(traffic);
      r.updates_sent = 4'(upd);
      return r;
   endfunction

   task automatic send_access(access_type a, logic typed = 1'b0, rsp_type fixed = '0);
      rsp_type p;
      if (allow_idle && $urandom_range(0, 99) < 22) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= a.op;
      req_set_index <= a.set;
      req_line_tag <= a.tag;
      req_other_copy <= a.other;
      req_sharer_count <= a.sharers;
      req_state_to_set <= a.want;
      do @(posedge clock); while (busy);
      p = cache_access(a);
      expected_rsp_q.push_back(typed ? fixed : p);
   endtask

   task automatic write_regs(logic mode, logic [8:0] ways, logic [8:0] words);
      start <= 1'b0;
      @(posedge clock);
      wait (expected_rsp_q.size() == 0);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_MODE;  csr_data <= {8'd0, mode};
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_WAYS;  csr_data <= ways;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_WORDS; csr_data <= words;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      m_dragon = mode;
      m_ways = int'(ways[2:0]);
      m_words = int'(words);
   endtask

   function automatic access_type random_access();
      access_type a;
      logic [19:0] pool [8] = '{20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5,
                                20'hFFFFF, 20'hA5A5A};
      int k;
      k = $urandom_range(0, 99);
      a.op = (k < 40) ? OP_READ : (k < 75) ? OP_WRITE : (k < 87) ? OP_QUERY : OP_SET;
      a.set = 6'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 3)
                                               : $urandom_range(0, 63));
      a.tag = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 7)]
                                            : 20'($urandom);
      a.other = 1'($urandom_range(0, 1));
      a.sharers = 4'($urandom_range(0, 15));
      a.want = 3'($urandom_range(0, 7));
      return a;
   endfunction

   function automatic void check_field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
         errors++;
         $display("%0t %s expected %0d actual %0d", $time, name, exp_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            errors++;
            $display("%0t unexpected response, expected none actual latency %0d",
                     $time, rsp_latency);
         end else begin
            e = expected_rsp_q.pop_front();
            check_field("latency", e.latency, rsp_latency);
            check_field("hit", e.hit, rsp_hit);
            check_field("line_state", e.line_state, rsp_line_state);
            check_field("wrote_back", e.wrote_back, rsp_wrote_back);
            check_field("shared_access", e.shared_access, rsp_shared_access);
            check_field("data_traffic", e.data_traffic, rsp_data_traffic);
            check_field("updates_sent", e.updates_sent, rsp_updates_sent);
         end
      end
   end

   dir_row_type dir_tab [19];
   logic       ph_mode  [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   logic [8:0] ph_ways  [8] = '{9'd4, 9'd4, 9'd1, 9'd2, 9'd0, 9'd7, 9'd3, 9'd4};
   logic [8:0] ph_words [8] = '{9'd8, 9'd8, 9'd1, 9'd511, 9'd0, 9'd256, 9'd4, 9'd2};

   initial begin
      access_type a;
      dir_tab = '{
         '{'{OP_READ,  6'd0,  20'd0,      1'b0, 4'd0,  ST_I},  1'b1,
           {14'd100, 1'b0, ST_E, 1'b0, 1'b0, 5'd1, 4'd0}},
         '{'{OP_QUERY, 6'd0,  20'd0,      1'b0, 4'd0,  ST_I},  1'b1,
           {14'd0, 1'b1, ST_E, 1'b0, 1'b0, 5'd0, 4'd0}},
         '{'{OP_WRITE, 6'd0,  20'd0,      1'b0, 4'd0,  ST_I},  1'b1,
           {14'd1, 1'b1, ST_M, 1'b0, 1'b0, 5'd0, 4'd0}},
         '{'{OP_READ,  6'd0,  20'hFFFFF,  1'b1, 4'd0,  ST_I},  1'b1,
           {14'd16, 1'b0, ST_S, 1'b0, 1'b1, 5'd1, 4'd0}},
         '{'{OP_WRITE, 6'd0,  20'hFFFFF,  1'b1, 4'd15, ST_I},  1'b1,
           {14'd31, 1'b1, ST_M, 1'b0, 1'b1, 5'd0, 4'd15}},
         '{'{OP_READ,  6'd0,  20'd1,      1'b0, 4'd0,  ST_I},  1'b0, '0},
         '{'{OP_READ,  6'd0,  20'd2,      1'b1, 4'd0,  ST_I},  1'b0, '0},
         '{'{OP_READ,  6'd0,  20'd3,      1'b0, 4'd0,  ST_I},  1'b0, '0},
         '{'{OP_QUERY, 6'd63, 20'd5,      1'b1, 4'd15, ST_MD}, 1'b1, '0},
         '{'{OP_READ,  6'd63, 20'd5,      1'b0, 4'd0,  ST_I},  1'b0, '0},
         '{'{OP_SET,   6'd63, 20'd5,      1'b0, 4'd0,  ST_MD}, 1'b1,
           {14'd0, 1'b1, ST_MD, 1'b0, 1'b0, 5'd0, 4'd0}},
         '{'{OP_WRITE, 6'd63, 20'd5,      1'b1, 4'd7,  ST_I},  1'b0, '0},
         '{'{OP_SET,   6'd63, 20'd5,      1'b0, 4'd0,  3'd7},  1'b0, '0},
         '{'{OP_SET,   6'd63, 20'd5,      1'b0, 4'd0,  ST_I},  1'b1,
           {14'd0, 1'b1, ST_I, 1'b0, 1'b0, 5'd0, 4'd0}},
         '{'{OP_READ,  6'd63, 20'd5,      1'b1, 4'd0,  ST_I},  1'b0, '0},
         '{'{OP_SET,   6'd10, 20'd9,      1'b0, 4'd0,  ST_M},  1'b1, '0},
         '{'{OP_READ,  6'd0,  20'd2,      1'b0, 4'd0,  ST_I},  1'b0, '0},
         '{'{OP_WRITE, 6'd0,  20'd1,      1'b0, 4'd0,  ST_I},  1'b0, '0},
         '{'{OP_WRITE, 6'd0,  20'hAAAAA,  1'b1, 4'd10, ST_I},  1'b0, '0}
      };
      for (int s = 0; s < NumSets; s++)
         for (int w = 0; w < MaxWays; w++) begin
            m_valid[s][w] = 1'b0; m_tag[s][w] = '0;
            m_state[s][w] = ST_I; m_rank[s][w] = 0;
         end
      m_dragon = 1'b0; m_ways = 4; m_words = 8;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_tab[i]) send_access(dir_tab[i].acc, dir_tab[i].typed, dir_tab[i].rsp);
      for (int p = 0; p < 8; p++) begin
         write_regs(ph_mode[p], ph_ways[p], ph_words[p]);
         allow_idle = (p != 2);
         // dirty fill then shared write miss: evicts and, at large blocks, saturates
         for (int j = 0; j < 5; j++)
            send_access('{OP_WRITE, 6'(8 + p), 20'(j), (j == 4), 4'd15, ST_I});
         repeat (62) begin
            a = random_access();
            send_access(a);
         end
      end
      start <= 1'b0;
      @(posedge clock);
      wait (expected_rsp_q.size() == 0);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
